/* rtl/ces_pkg.sv */
// Shared types and constants for the cubic edge stepper.
package ces_pkg;

	localparam int COORD_W     = 22;
	localparam int WORD_W      = 32;
	localparam int ROW_W       = 16;
	localparam int MAX_STEP_EXP = 6;
	localparam int SEG_CNT_W   = 7;
	localparam int EXP_W       = 3;
	localparam int QUO_W       = 39;
	localparam int DEN_W       = 23;
	localparam int DIV_CNT_W   = 6;

	localparam logic [WORD_W-1:0] SLOPE_POS_MAX = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] SLOPE_NEG_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [WORD_W-1:0] d1;
		logic [WORD_W-1:0] d2;
		logic [WORD_W-1:0] d3;
	} diff_t;

	// one prepared curve, handed from front to back
	typedef struct packed {
		logic [WORD_W-1:0] cur_x;
		logic [WORD_W-1:0] cur_y;
		logic [WORD_W-1:0] end_x;
		logic [WORD_W-1:0] end_y;
		diff_t             dx;
		diff_t             dy;
		logic [EXP_W-1:0]  step_exp;
		logic [EXP_W-1:0]  down_shift;
		logic              wind;
	} seg_rec_t;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_DELTA,
		FR_EXP,
		FR_SETUP,
		FR_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_STEP,
		BK_CLASS,
		BK_DIV,
		BK_SAT,
		BK_MUL,
		BK_EMIT
	} back_state_t;

endpackage

/* rtl/cubic_edge_stepper.sv */
// Top level of the cubic edge stepper: front, queue and back joined.
//
// Input channel: in_valid / in_stall carry one curve word, four 16.6 points.
// A curve with the end above the start is reversed and marked winding 1.
// Output channel: out_valid / out_stall carry one edge word per segment,
// 2^E words per curve with E from 1 to 6; last_segment marks the final one.
// A curve whose start and end round to the same row gives no word at all.
// Front steps per curve: order, chord deviation, exponent, setup, hand-off.
// Back: a covering segment goes through step, class, the bit-serial slope divider
// (39 quotient bits, one a cycle), saturation, multiply and emit; a segment
// covering no row goes from class straight to emit.
// The two-entry queue lets the front prepare following curves while the back part works.
// Reset clears every control state; queue and output are empty afterwards.
// While the receiver stalls the output word holds, the back part waits in its
// emit step, and the queue and then the front fill and raise in_stall.
module cubic_edge_stepper (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [21:0] p0_x,
	input  logic signed [21:0] p0_y,
	input  logic signed [21:0] p1_x,
	input  logic signed [21:0] p1_y,
	input  logic signed [21:0] p2_x,
	input  logic signed [21:0] p2_y,
	input  logic signed [21:0] p3_x,
	input  logic signed [21:0] p3_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] edge_x,
	output logic signed [31:0] edge_slope,
	output logic signed [15:0] first_row,
	output logic signed [15:0] last_row,
	output logic               winding,
	output logic               edge_valid,
	output logic               last_segment
);
	import ces_pkg::*;

	seg_rec_t wr_rec, rd_rec;
	logic     push, full, pop, empty;

	// classify and prepare each curve
	ces_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.p0_x     (p0_x),
		.p0_y     (p0_y),
		.p1_x     (p1_x),
		.p1_y     (p1_y),
		.p2_x     (p2_x),
		.p2_y     (p2_y),
		.p3_x     (p3_x),
		.p3_y     (p3_y),
		.rec      (wr_rec),
		.push     (push),
		.full     (full)
	);

	// hold prepared curves until the back part is free
	ces_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.full   (full),
		.pop    (pop),
		.rd_rec (rd_rec),
		.empty  (empty)
	);

	// walk the segments and emit one edge word each
	ces_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec          (rd_rec),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.edge_x       (edge_x),
		.edge_slope   (edge_slope),
		.first_row    (first_row),
		.last_row     (last_row),
		.winding      (winding),
		.edge_valid   (edge_valid),
		.last_segment (last_segment)
	);

endmodule

/* rtl/ces_front.sv */
// Front part: takes a curve word, orders it, picks the exponent and sets up differences.
module ces_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [21:0]     p0_x,
	input  logic signed [21:0]     p0_y,
	input  logic signed [21:0]     p1_x,
	input  logic signed [21:0]     p1_y,
	input  logic signed [21:0]     p2_x,
	input  logic signed [21:0]     p2_y,
	input  logic signed [21:0]     p3_x,
	input  logic signed [21:0]     p3_y,
	output ces_pkg::seg_rec_t      rec,
	output logic                   push,
	input  logic                   full
);
	import ces_pkg::*;

	front_state_t state_q, state_d;

	logic signed [COORD_W-1:0] px_q [4];
	logic signed [COORD_W-1:0] py_q [4];
	logic                      wind_q;
	logic [24:0]               dx_q, dy_q;
	logic [EXP_W-1:0]          e_q, ds_q;
	logic [3:0]                up_q;
	seg_rec_t                  rec_q;

	logic                      accept;
	logic                      swap;
	logic                      flat;
	logic [25:0]               dev_sum;
	logic [26:0]               dist_r;
	logic [4:0]                blen;
	logic [3:0]                e_raw;
	logic [EXP_W-1:0]          e_new;

	function automatic logic [24:0] chord(input logic signed [21:0] q0, input logic signed [21:0] q1,
			input logic signed [21:0] q2, input logic signed [21:0] q3);
		logic signed [27:0] s0, s1;
		logic signed [33:0] m0, m1;
		logic signed [24:0] a, b;
		logic [24:0]        ma, mb;
		s0 = (28'(q0) <<< 3) - ((28'(q1) <<< 4) - 28'(q1)) + (28'(q2) <<< 2) + (28'(q2) <<< 1)
			+ 28'(q3);
		s1 = 28'(q0) + (28'(q1) <<< 2) + (28'(q1) <<< 1) - ((28'(q2) <<< 4) - 28'(q2))
			+ (28'(q3) <<< 3);
		m0 = (34'(s0) <<< 4) + (34'(s0) <<< 1) + 34'(s0);
		m1 = (34'(s1) <<< 4) + (34'(s1) <<< 1) + 34'(s1);
		a  = 25'(m0 >>> 9);
		b  = 25'(m1 >>> 9);
		ma = a[24] ? 25'(-a) : 25'(a);
		mb = b[24] ? 25'(-b) : 25'(b);
		return (ma > mb) ? ma : mb;
	endfunction

	function automatic diff_t setup_axis(input logic signed [21:0] q0, input logic signed [21:0] q1,
			input logic signed [21:0] q2, input logic signed [21:0] q3,
			input logic [EXP_W-1:0] e, input logic [3:0] up);
		logic signed [39:0] t, u, w, a, b, c, a3, t3, s1;
		diff_t r;
		t  = 40'(q1) - 40'(q2);
		u  = 40'(q0) - (40'(q1) <<< 1) + 40'(q2);
		w  = 40'(q1) - 40'(q0);
		a  = (40'(q3) + (t <<< 1) + t - 40'(q0)) <<< up;
		b  = ((u <<< 1) + u) <<< up;
		c  = ((w <<< 1) + w) <<< up;
		a3 = (a <<< 1) + a;
		t3 = a3 >>> (e - 3'd1);
		s1 = (a >>> {e, 1'b0}) + (b >>> e) + c;
		r.d1 = s1[WORD_W-1:0];
		r.d2 = 32'(t3 + (b <<< 1));
		r.d3 = t3[WORD_W-1:0];
		return r;
	endfunction

	assign accept   = in_valid && (state_q == FR_IDLE);
	assign in_stall = (state_q != FR_IDLE);
	assign swap     = p0_y > p3_y;
	assign flat     = ((23'(py_q[0]) + 23'sd32) >>> 6) == ((23'(py_q[3]) + 23'sd32) >>> 6);

	always_comb begin
		dev_sum = (dx_q > dy_q) ? 26'(dx_q) + 26'(dy_q >> 1) : 26'(dy_q) + 26'(dx_q >> 1);
		dist_r  = (27'(dev_sum) + 27'd16) >> 5;
		blen    = '0;
		for (int i = 0; i < 27; i++) begin
			if (dist_r[i]) blen = 5'(i + 1);
		end
		e_raw = 4'(blen >> 1) + 4'd1;
		e_new = (e_raw > 4'(MAX_STEP_EXP)) ? EXP_W'(MAX_STEP_EXP) : e_raw[EXP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FR_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		unique case (state_q)
			FR_IDLE:  if (accept) state_d = FR_DELTA;
			FR_DELTA: state_d = flat ? FR_IDLE : FR_EXP;
			FR_EXP:   state_d = FR_SETUP;
			FR_SETUP: state_d = FR_PUSH;
			FR_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_d = FR_IDLE;
				end
			end
			default:  state_d = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			// reverse the point order for a rising curve
			px_q[0] <= swap ? p3_x : p0_x;
			px_q[1] <= swap ? p2_x : p1_x;
			px_q[2] <= swap ? p1_x : p2_x;
			px_q[3] <= swap ? p0_x : p3_x;
			py_q[0] <= swap ? p3_y : p0_y;
			py_q[1] <= swap ? p2_y : p1_y;
			py_q[2] <= swap ? p1_y : p2_y;
			py_q[3] <= swap ? p0_y : p3_y;
			wind_q  <= swap;
		end
		if (state_q == FR_DELTA) begin
			dx_q <= chord(px_q[0], px_q[1], px_q[2], px_q[3]);
			dy_q <= chord(py_q[0], py_q[1], py_q[2], py_q[3]);
		end
		if (state_q == FR_EXP) begin
			e_q  <= e_new;
			ds_q <= (e_new < 3'd4) ? 3'd0 : e_new - 3'd4;
			up_q <= (e_new < 3'd4) ? 4'd10 - 4'(e_new) : 4'd6;
		end
		if (state_q == FR_SETUP) begin
			rec_q.dx         <= setup_axis(px_q[0], px_q[1], px_q[2], px_q[3], e_q, up_q);
			rec_q.dy         <= setup_axis(py_q[0], py_q[1], py_q[2], py_q[3], e_q, up_q);
			rec_q.cur_x      <= {px_q[0], 10'b0};
			rec_q.cur_y      <= {py_q[0], 10'b0};
			rec_q.end_x      <= {px_q[3], 10'b0};
			rec_q.end_y      <= {py_q[3], 10'b0};
			rec_q.step_exp   <= e_q;
			rec_q.down_shift <= ds_q;
			rec_q.wind       <= wind_q;
		end
	end

	assign rec = rec_q;

endmodule

/* rtl/ces_fifo.sv */
// Two-entry queue of prepared curves between front and back.
module ces_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ces_pkg::seg_rec_t wr_rec,
	output logic              full,
	input  logic              pop,
	output ces_pkg::seg_rec_t rd_rec,
	output logic              empty
);
	import ces_pkg::*;

	seg_rec_t   mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign rd_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_rec;
	end

endmodule

/* rtl/ces_back.sv */
// Back part: steps the segments, divides for the slope and drives the result word.
module ces_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ces_pkg::seg_rec_t   rec,
	input  logic                empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  edge_x,
	output logic signed [31:0]  edge_slope,
	output logic signed [15:0]  first_row,
	output logic signed [15:0]  last_row,
	output logic                winding,
	output logic                edge_valid,
	output logic                last_segment
);
	import ces_pkg::*;

	back_state_t state_q, state_d;

	logic signed [WORD_W-1:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
	diff_t                    dx_q, dy_q;
	logic [EXP_W-1:0]         e_q, ds_q;
	logic                     wind_q, last_q;
	logic [SEG_CNT_W-1:0]     seg_left_q, seg_rem;
	logic signed [WORD_W-1:0] sx_q, sy_q, nx_q, ny_q;
	logic signed [WORD_W-1:0] nx, ny;

	logic signed [21:0]       y0, y1, x0, x1;
	logic signed [22:0]       y0p, y1p;
	logic signed [16:0]       top, bot;
	logic signed [22:0]       dxs;
	logic signed [16:0]       top_q, bot_q;
	logic signed [21:0]       x0_q;
	logic [6:0]               dyc_q;
	logic                     seg_ok_q, neg_q;
	logic [QUO_W-1:0]         quo_q;
	logic [DEN_W-1:0]         rem_q, den_q;
	logic [DEN_W:0]           trial;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic signed [WORD_W-1:0] slope_q;
	logic signed [38:0]       prod_q;
	logic signed [22:0]       xsum;
	logic                     load_out;

	assign seg_rem = seg_left_q - 7'd1;

	always_comb begin
		if (seg_rem != '0) begin
			nx = cur_x_q + (signed'(dx_q.d1) >>> ds_q);
			ny = cur_y_q + (signed'(dy_q.d1) >>> ds_q);
		end else begin
			nx = end_x_q;
			ny = end_y_q;
		end
		// pin a falling y to the previous one
		if (ny < cur_y_q) ny = cur_y_q;
	end

	assign y0  = sy_q[31:10];
	assign y1  = ny_q[31:10];
	assign x0  = sx_q[31:10];
	assign x1  = nx_q[31:10];
	assign y0p = 23'(y0) + 23'sd32;
	assign y1p = 23'(y1) + 23'sd32;
	assign top = 17'(y0p >>> 6);
	assign bot = 17'(y1p >>> 6);
	assign dxs = 23'(x1) - 23'(x0);
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign xsum  = 23'(x0_q) + 23'(prod_q >>> 16);
	assign load_out = (state_q == BK_EMIT) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = BK_STEP;
				end
			end
			BK_STEP:  state_d = BK_CLASS;
			BK_CLASS: state_d = (top != bot && y1 > y0) ? BK_DIV : BK_EMIT;
			BK_DIV:   if (cnt_q == DIV_CNT_W'(QUO_W - 1)) state_d = BK_SAT;
			BK_SAT:   state_d = BK_MUL;
			BK_MUL:   state_d = BK_EMIT;
			BK_EMIT:  if (load_out) state_d = last_q ? BK_IDLE : BK_STEP;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_x_q    <= rec.cur_x;
			cur_y_q    <= rec.cur_y;
			end_x_q    <= rec.end_x;
			end_y_q    <= rec.end_y;
			dx_q       <= rec.dx;
			dy_q       <= rec.dy;
			e_q        <= rec.step_exp;
			ds_q       <= rec.down_shift;
			wind_q     <= rec.wind;
			seg_left_q <= SEG_CNT_W'(1) << rec.step_exp;
		end
		if (state_q == BK_STEP) begin
			seg_left_q <= seg_rem;
			last_q     <= (seg_rem == '0);
			sx_q       <= cur_x_q;
			sy_q       <= cur_y_q;
			nx_q       <= nx;
			ny_q       <= ny;
			cur_x_q    <= nx;
			cur_y_q    <= ny;
			if (seg_rem != '0) begin
				dx_q.d1 <= dx_q.d1 + 32'(signed'(dx_q.d2) >>> e_q);
				dx_q.d2 <= dx_q.d2 + dx_q.d3;
				dy_q.d1 <= dy_q.d1 + 32'(signed'(dy_q.d2) >>> e_q);
				dy_q.d2 <= dy_q.d2 + dy_q.d3;
			end
		end
		if (state_q == BK_CLASS) begin
			top_q    <= top;
			bot_q    <= bot;
			x0_q     <= x0;
			dyc_q    <= 7'd64 - {1'b0, y0p[5:0]};
			seg_ok_q <= (top != bot) && (y1 > y0);
			neg_q    <= dxs[22];
			quo_q    <= {(dxs[22] ? 23'(-dxs) : dxs), 16'b0};
			rem_q    <= '0;
			den_q    <= 23'(23'(y1) - 23'(y0));
			cnt_q    <= '0;
		end
		if (state_q == BK_DIV) begin
			cnt_q <= cnt_q + 1'b1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
		if (state_q == BK_SAT) begin
			if (!neg_q)
				slope_q <= (quo_q > QUO_W'(SLOPE_POS_MAX)) ? SLOPE_POS_MAX : quo_q[31:0];
			else
				slope_q <= (quo_q > QUO_W'(SLOPE_NEG_MIN)) ? SLOPE_NEG_MIN : -quo_q[31:0];
		end
		if (state_q == BK_MUL) begin
			prod_q <= 39'(slope_q) * 39'(signed'({1'b0, dyc_q}));
		end
		if (load_out) begin
			edge_x       <= seg_ok_q ? {xsum[21:0], 10'b0} : '0;
			edge_slope   <= seg_ok_q ? slope_q : '0;
			first_row    <= seg_ok_q ? top_q[15:0] : '0;
			last_row     <= seg_ok_q ? 16'(bot_q - 17'sd1) : '0;
			winding      <= wind_q;
			edge_valid   <= seg_ok_q;
			last_segment <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       out_valid <= 1'b0;
		else if (load_out) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DIV |-> cnt_q < DIV_CNT_W'(QUO_W))
		else $error("divider ran past its last bit");

	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_STEP |-> seg_left_q != '0)
		else $error("segment step with no segment left");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && last_q) |=> state_q == BK_IDLE)
		else $error("back part did not finish after last segment");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the cubic edge stepper: directed and random curves.
`timescale 1ns / 1ps

module testbench;
	import ces_pkg::*;

	localparam int CLK_HI      = 6;
	localparam int CLK_LO      = 6;
	localparam int RESET_CYC   = 5;
	localparam int RAND_CURVES = 220;
	localparam int DRAIN_CYC   = 200;
	localparam int HOLD_CYC    = 3000;
	localparam int HOLD_AT     = 60;
	localparam int PAUSE_AT    = 120;
	localparam longint CYCLE_LIMIT = 12000000;
	localparam int COORD_MIN   = -2097152;
	localparam int COORD_MAX   = 2097151;
	localparam int ANY_COUNT   = -1;

	// one edge word as the block should give it
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] slope;
		logic signed [15:0] first;
		logic signed [15:0] last;
		logic               wind;
		logic               vld;
		logic               lastseg;
	} edge_word_t;

	// one directed curve; n_edges is typed in where obvious, else ANY_COUNT
	typedef struct {
		int pt[8];
		int n_edges;
	} curve_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [21:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] edge_x, edge_slope;
	logic signed [15:0] first_row, last_row;
	logic               winding, edge_valid, last_segment;

	edge_word_t edges_due[$];
	int         fails;
	int         curves_taken;
	longint     cyc;

	// stepper state, kept in step with the block
	longint pos_x, pos_y, end_px, end_py;
	longint fd_x, fd_y, sd_x, sd_y, td_x, td_y;
	int     seg_exp, seg_shift;
	logic   curve_wind;

	cubic_edge_stepper DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y),
		.p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.edge_x(edge_x), .edge_slope(edge_slope),
		.first_row(first_row), .last_row(last_row),
		.winding(winding), .edge_valid(edge_valid), .last_segment(last_segment)
	);

	always begin
		clk = 1'b1;
		#CLK_HI;
		clk = 1'b0;
		#CLK_LO;
	end

	// wrap to a signed 32-bit register value
	function automatic longint wrap32(longint v);
		logic signed [31:0] t;
		t = v[31:0];
		return longint'(t);
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// approximate off-chord deviation of the inner points along one axis
	function automatic longint chord_dev(longint q0, longint q1, longint q2, longint q3);
		longint a, b;
		a = mag(((q0 * 8 - q1 * 15 + q2 * 6 + q3) * 19) >>> 9);
		b = mag(((q0 + q1 * 6 - q2 * 15 + q3 * 8) * 19) >>> 9);
		return (a > b) ? a : b;
	endfunction

	function automatic int bit_len(longint v);
		int n;
		n = 0;
		while (v > 0 && n < 63) begin
			v = v >>> 1;
			n++;
		end
		return n;
	endfunction

	// scaled forward differences along one axis
	task automatic setup_diffs(input longint q0, q1, q2, q3, input int e, up,
			output longint d1, d2, d3);
		longint k, a, b, c;
		k = longint'(1) <<< up;
		a = (q3 + 3 * (q1 - q2) - q0) * k;
		b = 3 * (q0 - 2 * q1 + q2) * k;
		c = 3 * (q1 - q0) * k;
		d1 = wrap32((a >>> (2 * e)) + (b >>> e) + c);
		d2 = wrap32(((3 * a) >>> (e - 1)) + 2 * b);
		d3 = wrap32((3 * a) >>> (e - 1));
	endtask

	// queue the edge word of one segment between two stepped points
	task automatic queue_edge(input longint xs, ys, xe, ye, input logic lastseg);
		edge_word_t w;
		longint y0, y1, top, bot, x0, x1, slope, dyc;
		w = '{x: '0, slope: '0, first: '0, last: '0, wind: curve_wind, vld: 1'b0,
			lastseg: lastseg};
		y0 = ys >>> 10;
		y1 = ye >>> 10;
		top = (y0 + 32) >>> 6;
		bot = (y1 + 32) >>> 6;
		if (top != bot && y1 > y0) begin
			x0 = xs >>> 10;
			x1 = xe >>> 10;
			slope = ((x1 - x0) * 65536) / (y1 - y0);
			if (slope > 64'sd2147483647)
				slope = 64'sd2147483647;
			if (slope < -64'sd2147483648)
				slope = -64'sd2147483648;
			dyc = top * 64 + 32 - y0;
			w.x = 32'((x0 + ((slope * dyc) >>> 16)) * 1024);
			w.slope = slope[31:0];
			w.first = top[15:0];
			w.last = bot[15:0] - 16'sd1;
			w.vld = 1'b1;
		end
		edges_due.push_back(w);
	endtask

	// work out every edge word that one accepted curve causes
	task automatic predict_curve(input longint qx[4], qy[4], output int n);
		longint t, ddx, ddy, dev_sum, ox, oy, nx, ny;
		int e, up, left;
		n = 0;
		curve_wind = 1'b0;
		if (qy[0] > qy[3]) begin
			t = qx[0]; qx[0] = qx[3]; qx[3] = t;
			t = qx[1]; qx[1] = qx[2]; qx[2] = t;
			t = qy[0]; qy[0] = qy[3]; qy[3] = t;
			t = qy[1]; qy[1] = qy[2]; qy[2] = t;
			curve_wind = 1'b1;
		end
		// start and end on the same row: nothing comes out
		if (((qy[0] + 32) >>> 6) == ((qy[3] + 32) >>> 6))
			return;
		ddx = chord_dev(qx[0], qx[1], qx[2], qx[3]);
		ddy = chord_dev(qy[0], qy[1], qy[2], qy[3]);
		dev_sum = (ddx > ddy) ? ddx + ddy / 2 : ddy + ddx / 2;
		e = bit_len((dev_sum + 16) >>> 5) / 2 + 1;
		if (e > MAX_STEP_EXP)
			e = MAX_STEP_EXP;
		up = 6;
		if (e + up < 10) begin
			seg_shift = 0;
			up = 10 - e;
		end else begin
			seg_shift = e + up - 10;
		end
		seg_exp = e;
		setup_diffs(qx[0], qx[1], qx[2], qx[3], e, up, fd_x, sd_x, td_x);
		setup_diffs(qy[0], qy[1], qy[2], qy[3], e, up, fd_y, sd_y, td_y);
		pos_x = wrap32(qx[0] * 1024);
		pos_y = wrap32(qy[0] * 1024);
		end_px = wrap32(qx[3] * 1024);
		end_py = wrap32(qy[3] * 1024);
		left = 1 << e;
		while (left > 0) begin
			ox = pos_x;
			oy = pos_y;
			left--;
			if (left > 0) begin
				nx = wrap32(ox + (fd_x >>> seg_shift));
				fd_x = wrap32(fd_x + (sd_x >>> seg_exp));
				sd_x = wrap32(sd_x + td_x);
				ny = wrap32(oy + (fd_y >>> seg_shift));
				fd_y = wrap32(fd_y + (sd_y >>> seg_exp));
				sd_y = wrap32(sd_y + td_y);
			end else begin
				nx = end_px;
				ny = end_py;
			end
			// pin a falling step to the previous row position
			if (ny < oy)
				ny = oy;
			queue_edge(ox, oy, nx, ny, left == 0);
			pos_x = nx;
			pos_y = ny;
			n++;
		end
	endtask

	// offer one curve word and hold it until the block takes it
	task automatic offer_curve(input int pt[8], input int n_edges);
		longint qx[4], qy[4];
		int n;
		in_valid <= 1'b1;
		p0_x <= 22'(pt[0]); p0_y <= 22'(pt[1]); p1_x <= 22'(pt[2]); p1_y <= 22'(pt[3]);
		p2_x <= 22'(pt[4]); p2_y <= 22'(pt[5]); p3_x <= 22'(pt[6]); p3_y <= 22'(pt[7]);
		do
			@(posedge clk);
		while (in_stall);
		for (int i = 0; i < 4; i++) begin
			qx[i] = pt[2 * i];
			qy[i] = pt[2 * i + 1];
		end
		predict_curve(qx, qy, n);
		if (n_edges != ANY_COUNT && n != n_edges) begin
			$error("edge count: expected %0d, actual %0d", n_edges, n);
			fails++;
		end
		curves_taken++;
	endtask

	// drop valid for a random gap after a word, mostly none or short
	task automatic sender_gap();
		int r, g;
		r = $urandom_range(0, 99);
		g = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 4) : $urandom_range(15, 80);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// idle the sender until every expected word has come back
	task automatic drain_edges();
		in_valid <= 1'b0;
		@(posedge clk);
		while (edges_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic int clamp_coord(longint v);
		if (v < COORD_MIN)
			return COORD_MIN;
		if (v > COORD_MAX)
			return COORD_MAX;
		return int'(v);
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, 4194303)) - 2097152;
	endfunction

	// random curve: mostly small spans, a few medium, a rare one anywhere
	task automatic make_curve(output int pt[8]);
		int r, span, bx, by;
		r = $urandom_range(0, 99);
		span = (r < 80) ? 2000 : (r < 95) ? 40000 : 0;
		bx = any_coord();
		by = any_coord();
		for (int i = 0; i < 4; i++) begin
			if (span == 0) begin
				pt[2 * i] = any_coord();
				pt[2 * i + 1] = any_coord();
			end else begin
				pt[2 * i] = clamp_coord(longint'(bx) + $urandom_range(0, 2 * span) - span);
				pt[2 * i + 1] = clamp_coord(longint'(by) + $urandom_range(0, 2 * span) - span);
			end
		end
	endtask

	// directed curves: flats, straights both ways, steep slopes, extremes
	curve_row_t dir_rows [14] = '{
		'{'{0, 0, 100, 0, 200, 0, 300, 0}, 0},
		'{'{0, 0, 0, 10, 0, 20, 0, 31}, 0},
		'{'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX}, 0},
		'{'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN}, 0},
		'{'{0, 0, 0, 640, 0, 1280, 0, 1920}, 2},
		'{'{0, 1920, 0, 1280, 0, 640, 0, 0}, 2},
		'{'{COORD_MIN, 0, -699051, 32, 699050, 64, COORD_MAX, 96}, ANY_COUNT},
		'{'{COORD_MAX, 0, 699050, 32, -699051, 64, COORD_MIN, 96}, ANY_COUNT},
		'{'{0, 0, 100, -20000, 200, -20000, 300, 640}, ANY_COUNT},
		'{'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MAX, COORD_MAX}, ANY_COUNT},
		'{'{COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
			COORD_MIN, COORD_MIN}, ANY_COUNT},
		'{'{0, 0, COORD_MAX, 64, COORD_MIN, 128, 0, 192}, ANY_COUNT},
		'{'{-500, 100, 300, 900, 1200, 1500, 2000, 3000}, ANY_COUNT},
		'{'{64, -32, 64, 0, 64, 0, 64, 32}, ANY_COUNT}
	};

	// sender: reset, directed table, then random curves
	initial begin
		int pt[8];
		fails = 0;
		curves_taken = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		{p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y} = '0;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			offer_curve(dir_rows[i].pt, dir_rows[i].n_edges);
			sender_gap();
		end
		drain_edges();
		for (int i = 0; i < RAND_CURVES; i++) begin
			make_curve(pt);
			offer_curve(pt, ANY_COUNT);
			// hold off once with the pipe empty
			if (i == PAUSE_AT)
				drain_edges();
			else
				sender_gap();
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (edges_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold-off to fill the block
	initial begin
		int r, burst;
		logic held;
		out_stall = 1'b0;
		burst = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && curves_taken >= HOLD_AT) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYC) @(posedge clk);
				burst = 0;
			end
			if (burst == 0) begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					out_stall <= 1'b0;
					burst = $urandom_range(1, 25);
				end else if (r < 92) begin
					out_stall <= 1'b1;
					burst = $urandom_range(1, 4);
				end else begin
					out_stall <= 1'b1;
					burst = $urandom_range(20, 100);
				end
			end
			burst--;
		end
	end

	// compare every accepted edge word with the oldest one due
	always @(posedge clk) begin
		edge_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (edges_due.size() == 0) begin
				$error("edge word with nothing due: x %0d slope %0d", edge_x, edge_slope);
				fails++;
			end else begin
				w = edges_due.pop_front();
				if (edge_x !== w.x) begin
					$error("edge_x: expected %0d, actual %0d", w.x, edge_x);
					fails++;
				end
				if (edge_slope !== w.slope) begin
					$error("edge_slope: expected %0d, actual %0d", w.slope, edge_slope);
					fails++;
				end
				if (first_row !== w.first) begin
					$error("first_row: expected %0d, actual %0d", w.first, first_row);
					fails++;
				end
				if (last_row !== w.last) begin
					$error("last_row: expected %0d, actual %0d", w.last, last_row);
					fails++;
				end
				if (winding !== w.wind) begin
					$error("winding: expected %0b, actual %0b", w.wind, winding);
					fails++;
				end
				if (edge_valid !== w.vld) begin
					$error("edge_valid: expected %0b, actual %0b", w.vld, edge_valid);
					fails++;
				end
				if (last_segment !== w.lastseg) begin
					$error("last_segment: expected %0b, actual %0b", w.lastseg, last_segment);
					fails++;
				end
			end
		end
	end

	// guard against a hung block
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial cyc = 0;

endmodule
